### design/h263_picture_header_parser_core_defines.svh
// assertion helpers shared by the parser block
`ifndef H263_PICTURE_HEADER_PARSER_CORE_DEFINES_SVH
`define H263_PICTURE_HEADER_PARSER_CORE_DEFINES_SVH

// same-cycle implication, held off while in reset
`define HPH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser check failed");

// next-cycle implication, held off while in reset
`define HPH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

### design/h263ph_pkg.sv
`default_nettype none

package h263ph_pkg;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_START  = 3'd1;
  localparam logic [2:0] ST_BAD_MARKER = 3'd2;
  localparam logic [2:0] ST_BAD_ID     = 3'd3;
  localparam logic [2:0] ST_BAD_UPDATE = 3'd4;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd5;

  localparam logic [21:0] PSC_CODE     = 22'h000020;
  localparam logic [2:0]  FMT_EXTENDED = 3'd7;
  localparam logic [2:0]  FMT_CUSTOM   = 3'd6;

  // header field being collected
  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_START  = 5'd1,
    PH_TR     = 5'd2,
    PH_MARKER = 5'd3,
    PH_ID     = 5'd4,
    PH_SKIP3  = 5'd5,
    PH_FMT    = 5'd6,
    PH_TYPE1  = 5'd7,
    PH_MODES  = 5'd8,
    PH_QUANT  = 5'd9,
    PH_CPM    = 5'd10,
    PH_UFEP   = 5'd11,
    PH_XFMT   = 5'd12,
    PH_SKIP15 = 5'd13,
    PH_XTYPE  = 5'd14,
    PH_SKIP11 = 5'd15,
    PH_XW     = 5'd16,
    PH_SKIP1  = 5'd17,
    PH_XH     = 5'd18,
    PH_PEI    = 5'd19,
    PH_PSUPP  = 5'd20
  } phase_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       start_of_picture;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  source_format;
    logic [7:0]  temporal_ref;
    logic [3:0]  picture_type;
    logic [11:0] pic_width;
    logic [10:0] pic_height;
    logic [4:0]  quant_scale;
    logic [3:0]  mode_flags;
    logic [7:0]  extra_info_count;
  } out_item_t;

  // parser state carried from byte to byte
  typedef struct packed {
    phase_t      phase;
    logic [4:0]  bits_left;
    logic [21:0] shift;
    logic [7:0]  timestamp;
    logic [2:0]  format;
    logic [3:0]  ptype;
    logic [11:0] width;
    logic [10:0] height;
    logic [4:0]  quant;
    logic [3:0]  flags;
    logic [7:0]  count;
  } parse_st_t;

  typedef struct packed {
    parse_st_t  st;
    logic       hit;
    logic [2:0] status;
  } step_t;

  // standard picture sizes by source format
  function automatic logic [11:0] size_width(logic [2:0] fmt);
    logic [11:0] w;
    case (fmt)
      3'd1:    w = 12'd128;
      3'd2:    w = 12'd176;
      3'd3:    w = 12'd352;
      3'd4:    w = 12'd704;
      3'd5:    w = 12'd1408;
      3'd6:    w = 12'd320;
      default: w = 12'd0;
    endcase
    return w;
  endfunction

  function automatic logic [10:0] size_height(logic [2:0] fmt);
    logic [10:0] h;
    case (fmt)
      3'd1:    h = 11'd96;
      3'd2:    h = 11'd144;
      3'd3:    h = 11'd288;
      3'd4:    h = 11'd576;
      3'd5:    h = 11'd1152;
      3'd6:    h = 11'd240;
      default: h = 11'd0;
    endcase
    return h;
  endfunction

  // one bitstream bit through the parser
  function automatic step_t parse_bit(parse_st_t s, logic b);
    step_t       r;
    logic [21:0] v;
    logic [9:0]  wp;
    r        = '0;
    r.st     = s;
    r.status = ST_OK;
    v        = {s.shift[20:0], b};
    wp       = {1'b0, v[8:0]} + 10'd1;
    r.st.shift = v;
    if (s.bits_left != 5'd0) begin
      r.st.bits_left = s.bits_left - 5'd1;
    end
    if (r.st.bits_left == 5'd0) begin
      r.st.shift = '0;
      case (s.phase)
        PH_START: begin
          if (v != PSC_CODE) begin
            r.hit = 1'b1; r.status = ST_BAD_START;
          end else begin
            r.st.phase = PH_TR; r.st.bits_left = 5'd8;
          end
        end
        PH_TR: begin
          r.st.timestamp = v[7:0];
          r.st.phase = PH_MARKER; r.st.bits_left = 5'd1;
        end
        PH_MARKER: begin
          if (v != 22'd1) begin
            r.hit = 1'b1; r.status = ST_BAD_MARKER;
          end else begin
            r.st.phase = PH_ID; r.st.bits_left = 5'd1;
          end
        end
        PH_ID: begin
          if (v != 22'd0) begin
            r.hit = 1'b1; r.status = ST_BAD_ID;
          end else begin
            r.st.phase = PH_SKIP3; r.st.bits_left = 5'd3;
          end
        end
        PH_SKIP3: begin
          r.st.phase = PH_FMT; r.st.bits_left = 5'd3;
        end
        PH_FMT: begin
          r.st.format = v[2:0];
          if (v[2:0] != FMT_EXTENDED) begin
            r.st.width  = size_width(v[2:0]);
            r.st.height = size_height(v[2:0]);
            r.st.phase = PH_TYPE1; r.st.bits_left = 5'd1;
          end else begin
            r.st.phase = PH_UFEP; r.st.bits_left = 5'd3;
          end
        end
        PH_TYPE1: begin
          r.st.ptype = {3'd0, v[0]};
          r.st.phase = PH_MODES; r.st.bits_left = 5'd4;
        end
        PH_MODES: begin
          r.st.flags = v[3:0];
          r.st.phase = PH_QUANT; r.st.bits_left = 5'd5;
        end
        PH_QUANT: begin
          r.st.quant = v[4:0];
          r.st.phase = (s.format == FMT_EXTENDED) ? PH_PEI : PH_CPM;
          r.st.bits_left = 5'd1;
        end
        PH_CPM: begin
          r.st.phase = PH_PEI; r.st.bits_left = 5'd1;
        end
        PH_UFEP: begin
          if (v != 22'd1) begin
            r.hit = 1'b1; r.status = ST_BAD_UPDATE;
          end else begin
            r.st.phase = PH_XFMT; r.st.bits_left = 5'd3;
          end
        end
        PH_XFMT: begin
          if (v != {19'd0, FMT_CUSTOM}) begin
            r.hit = 1'b1; r.status = ST_BAD_FORMAT;
          end else begin
            r.st.phase = PH_SKIP15; r.st.bits_left = 5'd15;
          end
        end
        PH_SKIP15: begin
          r.st.phase = PH_XTYPE; r.st.bits_left = 5'd3;
        end
        PH_XTYPE: begin
          r.st.ptype = {1'b0, v[2:0]} + 4'd1;
          r.st.phase = PH_SKIP11; r.st.bits_left = 5'd11;
        end
        PH_SKIP11: begin
          r.st.phase = PH_XW; r.st.bits_left = 5'd9;
        end
        PH_XW: begin
          r.st.width = {wp, 2'b00};
          r.st.phase = PH_SKIP1; r.st.bits_left = 5'd1;
        end
        PH_SKIP1: begin
          r.st.phase = PH_XH; r.st.bits_left = 5'd9;
        end
        PH_XH: begin
          r.st.height = {v[8:0], 2'b00};
          r.st.phase = PH_QUANT; r.st.bits_left = 5'd5;
        end
        PH_PEI: begin
          if (v == 22'd0) begin
            r.hit = 1'b1; r.status = ST_OK;
          end else begin
            r.st.phase = PH_PSUPP; r.st.bits_left = 5'd8;
          end
        end
        PH_PSUPP: begin
          if (s.count != 8'hFF) begin
            r.st.count = s.count + 8'd1;
          end
          r.st.phase = PH_PEI; r.st.bits_left = 5'd1;
        end
        default: begin
          r.st.phase = PH_IDLE; r.st.bits_left = 5'd0;
        end
      endcase
      if (r.hit) begin
        r.st.phase = PH_IDLE; r.st.bits_left = 5'd0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/h263_picture_header_parser_core.sv
// H.263 picture header parser. Takes one bitstream byte per transaction, most
// significant bit first, and gives at most one result per header: on reaching
// the end of the extra-information bytes, or at the first check that fails.
// A byte with start_of_picture set restarts parsing from that byte; bytes that
// arrive outside a header are dropped. Each byte is held in an input
// register, then its eight bits go through the unrolled bit parser into the
// parser state and the result register, so a new byte is taken every cycle
// while the input side does not stall. The input side stalls only while a
// result waits in the output register and the output side is stalled.
`default_nettype none

module h263_picture_header_parser_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire h263ph_pkg::in_item_t  in_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      h263ph_pkg::out_item_t out_data
);
  import h263ph_pkg::*;

  `include "h263_picture_header_parser_core_defines.svh"

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_data_r;
  parse_st_t st_r, st_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_free;
  logic      advance;
  logic      hit;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // eight bit steps over the registered byte
  always_comb begin
    parse_st_t s;
    step_t     sr;
    logic      done;
    logic [2:0] code;
    s    = st_r;
    done = 1'b0;
    code = ST_OK;
    if (in_data_r.start_of_picture) begin
      s           = '0;
      s.phase     = PH_START;
      s.bits_left = 5'd22;
    end
    for (int i = 7; i >= 0; i--) begin
      sr = parse_bit(s, in_data_r.header_byte[i]);
      if (!done && s.phase != PH_IDLE) begin
        s = sr.st;
        if (sr.hit) begin
          done = 1'b1;
          code = sr.status;
        end
      end
    end
    hit    = done;
    st_nxt = st_r;
    if (advance) begin
      st_nxt = s;
    end
    out_data_nxt.status           = code;
    out_data_nxt.source_format    = s.format;
    out_data_nxt.temporal_ref     = s.timestamp;
    out_data_nxt.picture_type     = s.ptype;
    out_data_nxt.pic_width        = s.width;
    out_data_nxt.pic_height       = s.height;
    out_data_nxt.quant_scale      = s.quant;
    out_data_nxt.mode_flags       = s.flags;
    out_data_nxt.extra_info_count = s.count;
  end

  // parser state, all zero is the idle phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = advance && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  `HPH_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, in_valid_r && out_valid_r)
  `HPH_ASSERT_IMP(a_active_has_bits, clk, rst_n, st_r.phase != PH_IDLE,
                  st_r.bits_left != 5'd0)
  `HPH_ASSERT_NXT(a_idle_after_result, clk, rst_n, advance && hit, st_r.phase == PH_IDLE)
  `HPH_ASSERT_IMP(a_bad_start_clean, clk, rst_n,
                  out_valid_r && out_data_r.status == ST_BAD_START,
                  out_data_r.source_format == 3'd0 && out_data_r.pic_width == 12'd0 &&
                  out_data_r.extra_info_count == 8'd0)

endmodule

`default_nettype wire

### bench/h263_picture_header_parser_core_tb.sv
`timescale 1ns / 100ps

module h263_picture_header_parser_core_tb;
  import h263ph_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HEADER_BYTES = 1300;

  // ways a generated header can be broken
  typedef enum int {
    BRK_NONE,
    BRK_START,
    BRK_MARKER,
    BRK_ID,
    BRK_UFEP,
    BRK_XFMT
  } flaw_t;

  // expected header results and the parser state that produces them
  class header_scoreboard;
    out_item_t   awaited_headers[$];
    int          errors;
    phase_t      phase;
    int          bits_left;
    logic [21:0] shift;
    logic [7:0]  tr;
    logic [2:0]  fmt;
    logic [3:0]  ptype;
    logic [11:0] wid;
    logic [10:0] hgt;
    logic [4:0]  qnt;
    logic [3:0]  flags;
    logic [7:0]  extra;

    function new();
      errors = 0;
      clear_fields();
      goto_field(PH_IDLE, 0);
    endfunction

    function void clear_fields();
      tr = '0; fmt = '0; ptype = '0; wid = '0; hgt = '0;
      qnt = '0; flags = '0; extra = '0;
    endfunction

    function void goto_field(phase_t p, int n);
      phase = p;
      bits_left = n;
      shift = '0;
    endfunction

    // run the eight bits of one accepted byte through the header syntax
    function void take_byte(in_item_t it);
      logic [21:0] v;
      logic [2:0]  st;
      bit          done;
      out_item_t   r;
      if (it.start_of_picture) begin
        clear_fields();
        goto_field(PH_START, 22);
      end
      for (int i = 7; i >= 0 && phase != PH_IDLE; i--) begin
        shift = {shift[20:0], it.header_byte[i]};
        if (bits_left > 0) bits_left--;
        if (bits_left == 0) begin
          v = shift;
          done = 1'b0;
          st = ST_OK;
          case (phase)
            PH_START: begin
              if (v != PSC_CODE) begin
                done = 1'b1; st = ST_BAD_START;
              end else goto_field(PH_TR, 8);
            end
            PH_TR: begin
              tr = v[7:0];
              goto_field(PH_MARKER, 1);
            end
            PH_MARKER: begin
              if (v != 22'd1) begin
                done = 1'b1; st = ST_BAD_MARKER;
              end else goto_field(PH_ID, 1);
            end
            PH_ID: begin
              if (v != 22'd0) begin
                done = 1'b1; st = ST_BAD_ID;
              end else goto_field(PH_SKIP3, 3);
            end
            PH_SKIP3: goto_field(PH_FMT, 3);
            PH_FMT: begin
              fmt = v[2:0];
              if (fmt != FMT_EXTENDED) begin
                // standard picture sizes
                case (fmt)
                  3'd1: begin wid = 12'd128;  hgt = 11'd96;   end
                  3'd2: begin wid = 12'd176;  hgt = 11'd144;  end
                  3'd3: begin wid = 12'd352;  hgt = 11'd288;  end
                  3'd4: begin wid = 12'd704;  hgt = 11'd576;  end
                  3'd5: begin wid = 12'd1408; hgt = 11'd1152; end
                  3'd6: begin wid = 12'd320;  hgt = 11'd240;  end
                  default: begin wid = 12'd0; hgt = 11'd0; end
                endcase
                goto_field(PH_TYPE1, 1);
              end else goto_field(PH_UFEP, 3);
            end
            PH_TYPE1: begin
              ptype = {3'd0, v[0]};
              goto_field(PH_MODES, 4);
            end
            PH_MODES: begin
              flags = v[3:0];
              goto_field(PH_QUANT, 5);
            end
            PH_QUANT: begin
              qnt = v[4:0];
              goto_field((fmt == FMT_EXTENDED) ? PH_PEI : PH_CPM, 1);
            end
            PH_CPM: goto_field(PH_PEI, 1);
            PH_UFEP: begin
              if (v != 22'd1) begin
                done = 1'b1; st = ST_BAD_UPDATE;
              end else goto_field(PH_XFMT, 3);
            end
            PH_XFMT: begin
              if (v != {19'd0, FMT_CUSTOM}) begin
                done = 1'b1; st = ST_BAD_FORMAT;
              end else goto_field(PH_SKIP15, 15);
            end
            PH_SKIP15: goto_field(PH_XTYPE, 3);
            PH_XTYPE: begin
              ptype = {1'b0, v[2:0]} + 4'd1;
              goto_field(PH_SKIP11, 11);
            end
            PH_SKIP11: goto_field(PH_XW, 9);
            PH_XW: begin
              wid = ({3'd0, v[8:0]} + 12'd1) << 2;
              goto_field(PH_SKIP1, 1);
            end
            PH_SKIP1: goto_field(PH_XH, 9);
            PH_XH: begin
              hgt = {v[8:0], 2'b00};
              goto_field(PH_QUANT, 5);
            end
            PH_PEI: begin
              if (v == 22'd0) begin
                done = 1'b1; st = ST_OK;
              end else goto_field(PH_PSUPP, 8);
            end
            PH_PSUPP: begin
              if (extra != 8'hFF) extra++;
              goto_field(PH_PEI, 1);
            end
            default: goto_field(PH_IDLE, 0);
          endcase
          // one result per header, rest of the byte is dropped
          if (done) begin
            r.status           = st;
            r.source_format    = fmt;
            r.temporal_ref     = tr;
            r.picture_type     = ptype;
            r.pic_width        = wid;
            r.pic_height       = hgt;
            r.quant_scale      = qnt;
            r.mode_flags       = (fmt == FMT_EXTENDED) ? 4'd0 : flags;
            r.extra_info_count = extra;
            awaited_headers.push_back(r);
            goto_field(PH_IDLE, 0);
          end
        end
      end
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_header(out_item_t got);
      out_item_t exp_r;
      if (awaited_headers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = awaited_headers.pop_front();
      check_field("status", exp_r.status, got.status);
      check_field("source_format", exp_r.source_format, got.source_format);
      check_field("temporal_ref", exp_r.temporal_ref, got.temporal_ref);
      check_field("picture_type", exp_r.picture_type, got.picture_type);
      check_field("pic_width", exp_r.pic_width, got.pic_width);
      check_field("pic_height", exp_r.pic_height, got.pic_height);
      check_field("quant_scale", exp_r.quant_scale, got.quant_scale);
      check_field("mode_flags", exp_r.mode_flags, got.mode_flags);
      check_field("extra_info_count", exp_r.extra_info_count, got.extra_info_count);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  header_scoreboard sb;
  bit  hdr_bits[$];
  int  header_bytes;
  int  in_idle_pct;
  int  out_stall_pct;
  bit  hold_off_req;
  int  cycle_count;

  h263_picture_header_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) @(posedge clk);
    $display("h263_picture_header_parser_core verification failed");
    $finish;
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_byte(in_data);
      if (out_valid && !out_stall) sb.check_header(out_data);
    end
  end

  // result side: random stall, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // all-zero or all-one values half of the time, otherwise random
  function automatic int unsigned pick(int nbits);
    int unsigned m;
    m = (32'd1 << nbits) - 1;
    case ($urandom_range(3))
      0: return 0;
      1: return m;
      default: return $urandom & m;
    endcase
  endfunction

  function automatic void put_bits(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) hdr_bits.push_back(v[i]);
  endfunction

  // picture header as a bit string, optionally broken at one check
  function automatic void build_header(bit ext, flaw_t flaw, int n_extra, int fmt_sel);
    logic [21:0] psc;
    logic [2:0]  f;
    logic [2:0]  u;
    logic [2:0]  xf;
    hdr_bits.delete();
    psc = PSC_CODE;
    if (flaw == BRK_START) psc = psc ^ (22'd1 << $urandom_range(21));
    put_bits(psc, 22);
    put_bits(pick(8), 8);
    put_bits((flaw == BRK_MARKER) ? 0 : 1, 1);
    put_bits((flaw == BRK_ID) ? 1 : 0, 1);
    put_bits(pick(3), 3);
    if (!ext) begin
      f = 3'((fmt_sel < 0) ? $urandom_range(6) : fmt_sel);
      put_bits(f, 3);
      put_bits(pick(1), 1);
      put_bits(pick(4), 4);
      put_bits(pick(5), 5);
      put_bits(pick(1), 1);
    end else begin
      put_bits(FMT_EXTENDED, 3);
      u = 3'd1;
      if (flaw == BRK_UFEP) begin
        u = 3'($urandom_range(7));
        if (u == 3'd1) u = 3'd0;
      end
      put_bits(u, 3);
      xf = FMT_CUSTOM;
      if (flaw == BRK_XFMT) begin
        xf = 3'($urandom_range(7));
        if (xf == FMT_CUSTOM) xf = FMT_EXTENDED;
      end
      put_bits(xf, 3);
      put_bits(pick(15), 15);
      put_bits(pick(3), 3);
      put_bits(pick(11), 11);
      put_bits(pick(9), 9);
      put_bits(pick(1), 1);
      put_bits(pick(9), 9);
      put_bits(pick(5), 5);
    end
    repeat (n_extra) begin
      put_bits(1, 1);
      put_bits(pick(8), 8);
    end
    put_bits(0, 1);
  endfunction

  // one input transaction; entered and left at a falling edge
  task automatic send_byte(in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // pack the header bits into bytes, padding the tail with random bits
  task automatic send_bits(int cut);
    int        nbytes;
    int        idx;
    in_item_t  it;
    nbytes = (hdr_bits.size() + 7) / 8;
    if (cut > 0 && cut < nbytes) nbytes = cut;
    for (int k = 0; k < nbytes; k++) begin
      for (int j = 0; j < 8; j++) begin
        idx = k * 8 + j;
        it.header_byte[7 - j] = (idx < hdr_bits.size()) ? hdr_bits[idx]
                                                         : 1'($urandom_range(1));
      end
      it.start_of_picture = (k == 0);
      send_byte(it);
    end
    header_bytes += nbytes;
  endtask

  task automatic send_noise(int n);
    in_item_t it;
    repeat (n) begin
      it.header_byte = 8'($urandom);
      it.start_of_picture = 1'b0;
      send_byte(it);
    end
  endtask

  // stimulus and end of run
  initial begin
    int    hdr_no;
    int    choice;
    int    cut;
    flaw_t flaw;
    in_item_t it;
    sb = new();
    header_bytes = 0;
    in_idle_pct = 22;
    out_stall_pct = 22;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: bytes while idle, every failing check, format zero,
    // both paths with extra info, start during a header
    it.start_of_picture = 1'b0;
    it.header_byte = 8'h00;
    send_byte(it);
    it.header_byte = 8'hFF;
    send_byte(it);
    build_header(1'b0, BRK_START, 0, -1);  send_bits(0);
    build_header(1'b0, BRK_MARKER, 0, -1); send_bits(0);
    build_header(1'b0, BRK_ID, 0, -1);     send_bits(0);
    build_header(1'b1, BRK_UFEP, 0, -1);   send_bits(0);
    build_header(1'b1, BRK_XFMT, 0, -1);   send_bits(0);
    build_header(1'b0, BRK_NONE, 2, 0);    send_bits(0);
    build_header(1'b0, BRK_NONE, 0, 3);    send_bits(4);
    build_header(1'b1, BRK_NONE, 1, -1);   send_bits(0);

    // random headers, mostly well formed
    hdr_no = 0;
    while (header_bytes < HEADER_BYTES) begin
      hdr_no++;
      if (hdr_no == 20) begin
        // long run of extra info to saturate the count
        build_header(1'b0, BRK_NONE, 262, -1);
        send_bits(0);
      end
      if (hdr_no == 60) hold_off_req = 1'b1;
      if (hdr_no == 80) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      if (hdr_no == 110) begin
        in_idle_pct = 22;
        out_stall_pct = 22;
      end
      choice = $urandom_range(99);
      cut = 0;
      if (choice < 50) begin
        build_header(1'b0, BRK_NONE, $urandom_range(3), -1);
      end else if (choice < 78) begin
        build_header(1'b1, BRK_NONE, $urandom_range(3), -1);
      end else if (choice < 90) begin
        flaw = flaw_t'($urandom_range(BRK_START, BRK_XFMT));
        build_header(flaw == BRK_UFEP || flaw == BRK_XFMT, flaw, 0, -1);
      end else if (choice < 96) begin
        // cut short, the next header restarts it
        build_header(1'($urandom_range(1)), BRK_NONE, $urandom_range(2), -1);
        cut = $urandom_range(1, (hdr_bits.size() + 7) / 8 - 1);
      end
      if (choice < 96) send_bits(cut);
      else send_noise($urandom_range(1, 3));
    end
    in_valid <= 1'b0;

    while (sb.awaited_headers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.awaited_headers.size() == 0) begin
      $display("h263_picture_header_parser_core verification clean");
    end else begin
      $display("h263_picture_header_parser_core verification failed");
    end
    $finish;
  end

endmodule
